FILE: design/flb_pkg.sv
// flb_pkg: shared types and constants of the led panel ethernet frame builder
`default_nettype none

package flb_pkg;

  // input operation codes
  localparam logic OP_PIXEL     = 1'b0;
  localparam logic OP_END_FRAME = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_VLAN_ENABLE      = 3'd0;
  localparam logic [2:0] REG_VLAN_TAG_ID      = 3'd1;
  localparam logic [2:0] REG_COLUMN_COUNT     = 3'd2;
  localparam logic [2:0] REG_ROW_COUNT        = 3'd3;
  localparam logic [2:0] REG_BRIGHTNESS_RAW   = 3'd4;
  localparam logic [2:0] REG_BRIGHTNESS_GAMMA = 3'd5;

  // ethernet header pieces
  localparam logic [7:0] MAC_BYTES [12] = '{
    8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66,
    8'h22, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66
  };
  localparam logic [15:0] TPID_VLAN        = 16'h8100;
  localparam logic [3:0]  VLAN_PCP_HI      = 4'hE;
  localparam logic [15:0] TYPE_ROW         = 16'h5500;
  localparam logic [15:0] TYPE_SYNC        = 16'h0107;
  localparam logic [15:0] TYPE_BRIGHT_BASE = 16'h0A00;

  // row header trailer and sync payload marks
  localparam logic [7:0] ROW_MARK_A = 8'h08;
  localparam logic [7:0] ROW_MARK_B = 8'h88;
  localparam logic [7:0] SYNC_MODE  = 8'h05;
  localparam logic [7:0] BRIGHT_MAX = 8'hFF;

  // frame lengths and offsets in bytes
  localparam logic [6:0] ETH_HDR_LEN    = 7'd14;
  localparam logic [6:0] VLAN_TAG_LEN   = 7'd4;
  localparam logic [6:0] ROW_HDR_EXTRA  = 7'd7;
  localparam logic [6:0] SYNC_LEN       = 7'd112;
  localparam logic [6:0] BRIGHT_LEN     = 7'd77;
  localparam logic [6:0] SYNC_RAW_POS   = 7'd21;
  localparam logic [6:0] SYNC_MODE_POS  = 7'd22;
  localparam logic [6:0] SYNC_RUN_FIRST = 7'd24;
  localparam logic [6:0] SYNC_RUN_LAST  = 7'd26;

  // which frame the word sequencer is cutting
  typedef enum logic [1:0] {
    SEG_PIX,
    SEG_ROW,
    SEG_SYNC,
    SEG_BRIGHT
  } seg_t;

  // live configuration seen by the formatter
  typedef struct packed {
    logic        vlan_enable;
    logic [11:0] vlan_tag_id;
    logic [8:0]  cols_eff;
    logic [7:0]  brightness_raw;
    logic [7:0]  brightness_gamma;
  } cfg_t;

  // one accepted item with the row context it saw
  typedef struct packed {
    logic        eof;
    logic        header;
    logic        row_end;
    logic [15:0] row_id;
    logic [7:0]  pixel;
  } job_t;

  // one formatted word
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  count;
    logic        frame_last;
    logic        eop;
  } fmt_t;

endpackage

`default_nettype wire

FILE: design/flb_row_track.sv
// flb_row_track: row index and byte position tracking, job descriptor per item
`default_nettype none

module flb_row_track #(
  parameter int MAX_COLUMNS = 496,
  parameter int MAX_ROWS    = 512,
  parameter int PIXEL_BYTES = 3
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic              operation,
  input  wire logic [7:0]        pixel_byte,
  input  wire logic [8:0]        cols_eff,
  input  wire logic [9:0]        row_count,
  output flb_pkg::job_t          job
);

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W = $clog2(MAX_ROWS + 1);
  localparam int RC_W  = (CNT_W > 10) ? CNT_W : 10;
  localparam int BW    = $clog2(MAX_COLUMNS * PIXEL_BYTES + 1);

  logic [ROW_W-1:0] row_index;
  logic [ROW_W-1:0] row_index_next;
  logic [BW-1:0]    byte_in_row;
  logic [BW-1:0]    byte_in_row_next;

  logic [BW-1:0]    row_len;
  logic [BW:0]      byte_inc;
  logic             row_end;
  logic [RC_W-1:0]  rows_raw;
  logic [RC_W-1:0]  rows_eff;
  logic [RC_W-1:0]  row_inc;

  // row length in bytes and end-of-row test
  assign row_len  = BW'(cols_eff * PIXEL_BYTES);
  assign byte_inc = {1'b0, byte_in_row} + {{BW{1'b0}}, 1'b1};
  assign row_end  = byte_inc >= {1'b0, row_len};

  // saturated row count and wrap
  assign rows_raw = RC_W'(row_count);
  always_comb begin
    if (rows_raw == '0) begin
      rows_eff = {{(RC_W-1){1'b0}}, 1'b1};
    end else if (rows_raw > RC_W'(MAX_ROWS)) begin
      rows_eff = RC_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_raw;
    end
  end
  assign row_inc = RC_W'(row_index) + {{(RC_W-1){1'b0}}, 1'b1};

  // descriptor of the item at the input
  always_comb begin
    job.eof     = (operation == flb_pkg::OP_END_FRAME);
    job.header  = (byte_in_row == '0);
    job.row_end = row_end;
    job.row_id  = 16'(row_index);
    job.pixel   = pixel_byte;
  end

  // state after this item
  always_comb begin
    row_index_next   = row_index;
    byte_in_row_next = byte_in_row;
    if (operation == flb_pkg::OP_END_FRAME) begin
      row_index_next   = '0;
      byte_in_row_next = '0;
    end else if (row_end) begin
      byte_in_row_next = '0;
      row_index_next   = (row_inc >= rows_eff) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      byte_in_row_next = byte_inc[BW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index   <= '0;
      byte_in_row <= '0;
    end else if (accept) begin
      row_index   <= row_index_next;
      byte_in_row <= byte_in_row_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/flb_word_fmt.sv
// flb_word_fmt: builds one 8-byte frame word from frame kind and word number
`default_nettype none

module flb_word_fmt (
  input  wire flb_pkg::seg_t seg,
  input  wire logic [3:0]    widx,
  input  wire flb_pkg::cfg_t cfg,
  input  wire flb_pkg::job_t job,
  output flb_pkg::fmt_t      fmt
);

  logic [6:0]  hdr_len;
  logic [6:0]  frame_len;
  logic [6:0]  word_pos;
  logic [6:0]  remain;
  logic [3:0]  count;
  logic [15:0] type_code;

  // one byte of the frame at position p
  function automatic logic [7:0] frame_byte(
    input flb_pkg::seg_t s,
    input logic [6:0]    p,
    input logic [6:0]    b,
    input logic [15:0]   tc,
    input flb_pkg::cfg_t c,
    input flb_pkg::job_t j
  );
    logic [6:0] q;
    logic [7:0] v;
    begin
      q = p - b;
      v = 8'h00;
      if (s == flb_pkg::SEG_PIX) begin
        v = j.pixel;
      end else if (p < 7'd12) begin
        v = flb_pkg::MAC_BYTES[p[3:0]];
      end else if (c.vlan_enable && p < 7'd16) begin
        case (p[1:0])
          2'd0:    v = flb_pkg::TPID_VLAN[15:8];
          2'd1:    v = flb_pkg::TPID_VLAN[7:0];
          2'd2:    v = {flb_pkg::VLAN_PCP_HI, c.vlan_tag_id[11:8]};
          default: v = c.vlan_tag_id[7:0];
        endcase
      end else if (p == b - 7'd2) begin
        v = tc[15:8];
      end else if (p == b - 7'd1) begin
        v = tc[7:0];
      end else begin
        case (s)
          flb_pkg::SEG_ROW: begin
            case (q)
              7'd0:    v = j.row_id[7:0];
              7'd1:    v = j.row_id[15:8];
              7'd3:    v = {7'b0, c.cols_eff[8]};
              7'd4:    v = c.cols_eff[7:0];
              7'd5:    v = flb_pkg::ROW_MARK_A;
              7'd6:    v = flb_pkg::ROW_MARK_B;
              7'd7:    v = j.pixel;
              default: v = 8'h00;
            endcase
          end
          flb_pkg::SEG_SYNC: begin
            if (q == flb_pkg::SYNC_RAW_POS ||
                (q >= flb_pkg::SYNC_RUN_FIRST && q <= flb_pkg::SYNC_RUN_LAST)) begin
              v = c.brightness_raw;
            end else if (q == flb_pkg::SYNC_MODE_POS) begin
              v = flb_pkg::SYNC_MODE;
            end
          end
          flb_pkg::SEG_BRIGHT: begin
            case (q)
              7'd0, 7'd1: v = c.brightness_gamma;
              7'd2:       v = flb_pkg::BRIGHT_MAX;
              default:    v = 8'h00;
            endcase
          end
          default: v = 8'h00;
        endcase
      end
      frame_byte = v;
    end
  endfunction

  // header length, frame length and type
  assign hdr_len = cfg.vlan_enable ? flb_pkg::ETH_HDR_LEN + flb_pkg::VLAN_TAG_LEN
                                   : flb_pkg::ETH_HDR_LEN;
  always_comb begin
    case (seg)
      flb_pkg::SEG_PIX: begin
        frame_len = 7'd1;
        type_code = flb_pkg::TYPE_ROW;
      end
      flb_pkg::SEG_ROW: begin
        frame_len = hdr_len + flb_pkg::ROW_HDR_EXTRA + 7'd1;
        type_code = flb_pkg::TYPE_ROW;
      end
      flb_pkg::SEG_SYNC: begin
        frame_len = flb_pkg::SYNC_LEN + (hdr_len - flb_pkg::ETH_HDR_LEN);
        type_code = flb_pkg::TYPE_SYNC;
      end
      default: begin
        frame_len = flb_pkg::BRIGHT_LEN + (hdr_len - flb_pkg::ETH_HDR_LEN);
        type_code = flb_pkg::TYPE_BRIGHT_BASE + {8'h00, cfg.brightness_gamma};
      end
    endcase
  end

  // bytes left from this word on
  assign word_pos = {widx, 3'b000};
  assign remain   = frame_len - word_pos;
  assign count    = (remain > 7'd8) ? 4'd8 : remain[3:0];

  // pack the word, first byte on top, unused bytes zero
  always_comb begin
    fmt.word = '0;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < count) begin
        fmt.word[63 - 8*k -: 8] = frame_byte(seg, word_pos + 7'(k), hdr_len,
                                             type_code, cfg, job);
      end
    end
    fmt.count      = count;
    fmt.frame_last = (remain <= 7'd8);
    fmt.eop        = (remain <= 7'd8) &&
                     ((seg == flb_pkg::SEG_SYNC) || (seg == flb_pkg::SEG_BRIGHT) ||
                      job.row_end);
  end

endmodule

`default_nettype wire

FILE: design/flb_word_seq.sv
// flb_word_seq: job register, word stepping and output register
`default_nettype none

module flb_word_seq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire flb_pkg::job_t job_in,
  output flb_pkg::job_t      job,
  output flb_pkg::seg_t      seg,
  output logic [3:0]         widx,
  input  wire flb_pkg::fmt_t fmt,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [63:0]        frame_word,
  output logic [3:0]         byte_count,
  output logic               end_of_packet,
  output logic               last_result
);

  logic          job_valid;
  logic          advance;
  logic          job_done;
  logic          accept;
  flb_pkg::seg_t seg_next;
  logic [3:0]    widx_next;

  // outputs of the sequencer
  always_comb begin
    advance  = job_valid && (!out_valid || out_ready);
    job_done = advance && fmt.frame_last && (seg != flb_pkg::SEG_SYNC);
    in_ready = !job_valid || job_done;
    accept   = in_valid && in_ready;
  end

  // next frame kind and word number
  always_comb begin
    seg_next  = seg;
    widx_next = widx;
    if (accept) begin
      widx_next = '0;
      if (job_in.eof) begin
        seg_next = flb_pkg::SEG_SYNC;
      end else if (job_in.header) begin
        seg_next = flb_pkg::SEG_ROW;
      end else begin
        seg_next = flb_pkg::SEG_PIX;
      end
    end else if (advance && !job_done) begin
      unique case (seg)
        flb_pkg::SEG_SYNC: begin
          if (fmt.frame_last) begin
            seg_next  = flb_pkg::SEG_BRIGHT;
            widx_next = '0;
          end else begin
            widx_next = widx + 4'd1;
          end
        end
        flb_pkg::SEG_PIX, flb_pkg::SEG_ROW, flb_pkg::SEG_BRIGHT: begin
          widx_next = widx + 4'd1;
        end
        default: widx_next = widx;
      endcase
    end
  end

  // job register
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      seg       <= flb_pkg::SEG_PIX;
      widx      <= '0;
    end else begin
      seg  <= seg_next;
      widx <= widx_next;
      if (accept) begin
        job_valid <= 1'b1;
      end else if (job_done) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_in;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame_word    <= fmt.word;
      byte_count    <= fmt.count;
      end_of_packet <= fmt.eop;
      last_result   <= fmt.frame_last && (seg != flb_pkg::SEG_SYNC);
    end
  end

endmodule

`default_nettype wire

FILE: design/led_panel_ethernet_frame_builder_unit.sv
// led_panel_ethernet_frame_builder_unit: top level of the led panel frame builder
`default_nettype none

// Pixel bytes go in one per beat in row-major order; raw ethernet frames come out
// as words of up to eight bytes, first byte in bits 63..56. A pixel byte in the
// middle of a row makes one word, and a new byte is taken every cycle while the
// output is not stalled. The byte that opens a row also carries the row header
// and makes 3 words (4 with a vlan tag); an end-of-frame beat sends the sync and
// brightness frames as 24 words (26 with a tag). These counts are set by the word
// formatter, which makes one 8-byte word per cycle unless the output stalls. An
// input beat goes to the job register and its words to the output register.
// Configuration writes are always taken; write them only while the block is idle.
module led_panel_ethernet_frame_builder_unit #(
  parameter int MAX_COLUMNS = 496,
  parameter int MAX_ROWS    = 512,
  parameter int PIXEL_BYTES = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [7:0]  pixel_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      frame_word,
  output logic [3:0]       byte_count,
  output logic             end_of_packet,
  output logic             last_result
);

  logic          vlan_enable;
  logic [11:0]   vlan_tag_id;
  logic [8:0]    column_count;
  logic [9:0]    row_count;
  logic [7:0]    brightness_raw;
  logic [7:0]    brightness_gamma;
  logic [8:0]    cols_eff;
  logic          in_accept;
  flb_pkg::cfg_t cfg;
  flb_pkg::job_t job_in;
  flb_pkg::job_t job;
  flb_pkg::seg_t seg;
  logic [3:0]    widx;
  flb_pkg::fmt_t fmt;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      vlan_enable      <= 1'b0;
      vlan_tag_id      <= 12'd0;
      column_count     <= 9'd128;
      row_count        <= 10'd64;
      brightness_raw   <= 8'd255;
      brightness_gamma <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        flb_pkg::REG_VLAN_ENABLE:      vlan_enable      <= cfg_data[0];
        flb_pkg::REG_VLAN_TAG_ID:      vlan_tag_id      <= cfg_data;
        flb_pkg::REG_COLUMN_COUNT:     column_count     <= cfg_data[8:0];
        flb_pkg::REG_ROW_COUNT:        row_count        <= cfg_data[9:0];
        flb_pkg::REG_BRIGHTNESS_RAW:   brightness_raw   <= cfg_data[7:0];
        flb_pkg::REG_BRIGHTNESS_GAMMA: brightness_gamma <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // column count saturated to 1..MAX_COLUMNS
  always_comb begin
    if (column_count == 9'd0) begin
      cols_eff = 9'd1;
    end else if (column_count > 9'(MAX_COLUMNS)) begin
      cols_eff = 9'(MAX_COLUMNS);
    end else begin
      cols_eff = column_count;
    end
  end

  always_comb begin
    cfg.vlan_enable      = vlan_enable;
    cfg.vlan_tag_id      = vlan_tag_id;
    cfg.cols_eff         = cols_eff;
    cfg.brightness_raw   = brightness_raw;
    cfg.brightness_gamma = brightness_gamma;
  end

  assign in_accept = in_valid && in_ready;

  flb_row_track #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .PIXEL_BYTES (PIXEL_BYTES)
  ) u_row_track (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .operation  (operation),
    .pixel_byte (pixel_byte),
    .cols_eff   (cols_eff),
    .row_count  (row_count),
    .job        (job_in)
  );

  flb_word_fmt u_word_fmt (
    .seg  (seg),
    .widx (widx),
    .cfg  (cfg),
    .job  (job),
    .fmt  (fmt)
  );

  flb_word_seq u_word_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .job_in        (job_in),
    .job           (job),
    .seg           (seg),
    .widx          (widx),
    .fmt           (fmt),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_word    (frame_word),
    .byte_count    (byte_count),
    .end_of_packet (end_of_packet),
    .last_result   (last_result)
  );

endmodule

`default_nettype wire

FILE: design/flb_checker.sv
// flb_checker: port-level checks on the frame builder output stream
`default_nettype none

module flb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] frame_word,
  input wire logic [3:0]  byte_count,
  input wire logic        end_of_packet,
  input wire logic        last_result
);

  // a stalled output beat holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_word) && $stable(byte_count))
    else $error("output beat changed while stalled");

  // byte count stays in 1..8
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_count != 4'd0 && byte_count <= 4'd8)
    else $error("byte count out of range");

  // a short word only ends a frame or an item
  a_short_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_count != 4'd8 |-> end_of_packet || last_result)
    else $error("short word in the middle of a frame");

  // a single-byte word has its unused bytes cleared
  a_single_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_count == 4'd1 |-> frame_word[55:0] == 56'd0)
    else $error("unused bytes not zero");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind led_panel_ethernet_frame_builder_unit flb_checker u_flb_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .frame_word    (frame_word),
  .byte_count    (byte_count),
  .end_of_packet (end_of_packet),
  .last_result   (last_result)
);

`default_nettype wire
